>>> rtl/motor_feedback_angle_unwrap_speed_filter_defines.svh
// Assertion macros shared by the RTL files.
`ifndef MOTOR_FEEDBACK_ANGLE_UNWRAP_SPEED_FILTER_DEFINES_SVH
`define MOTOR_FEEDBACK_ANGLE_UNWRAP_SPEED_FILTER_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define MFA_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset.
`define MFA_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> rtl/mfa_pkg.sv
package mfa_pkg;

   localparam int NUM_MOTORS_DEF = 4;

   localparam int MOTOR_W  = 2;
   localparam int ANGLE_W  = 13;
   localparam int TOTAL_W  = 32;
   localparam int SPEED_W  = 21;
   localparam int RPM_W    = 16;
   localparam int CUR_W    = 16;
   localparam int SCALE_W  = 16;
   localparam int WEIGHT_W = 9;

   localparam int DELTA_W  = ANGLE_W + 2;
   localparam int PROD_W   = 33;

   localparam logic signed [DELTA_W-1:0] TURN_COUNTS = DELTA_W'(8192);

   localparam logic [SCALE_W-1:0]  SCALE_RESET  = SCALE_W'(7244);
   localparam logic [WEIGHT_W-1:0] WEIGHT_RESET = WEIGHT_W'(154);
   localparam logic [WEIGHT_W-1:0] WEIGHT_ONE   = WEIGHT_W'(256);

   localparam logic signed [SPEED_W-1:0] SPEED_MAX = {1'b0, {(SPEED_W-1){1'b1}}};
   localparam logic signed [SPEED_W-1:0] SPEED_MIN = {1'b1, {(SPEED_W-1){1'b0}}};

   // Operation codes
   localparam logic OP_FEEDBACK = 1'b0;
   localparam logic OP_CLEAR    = 1'b1;

   // Control/status register map
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 16;
   localparam logic [CSR_IDX_W-1:0] CSR_SPEED_SCALE      = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_SMOOTHING_WEIGHT = 1'b1;

   typedef struct packed {
      logic rd_en;
      logic wr_en;
      logic clr_total;
   } store_ctl_type;

   typedef struct packed {
      logic ld_read;
      logic ld_samp;
      logic ld_filt;
   } calc_ctl_type;

   // Divide by 256 rounding half up, then clamp to the speed range.
   function automatic logic signed [SPEED_W-1:0] round_q8_sat(input logic signed [PROD_W-1:0] v);
      logic signed [PROD_W:0]   t;
      logic signed [PROD_W-8:0] r;
      logic signed [SPEED_W-1:0] res;
      t = (PROD_W+1)'(v) + (PROD_W+1)'(128);
      r = t[PROD_W:8];
      if (r > (PROD_W-7)'(SPEED_MAX)) begin
         res = SPEED_MAX;
      end else if (r < (PROD_W-7)'(SPEED_MIN)) begin
         res = SPEED_MIN;
      end else begin
         res = r[SPEED_W-1:0];
      end
      return res;
   endfunction

endpackage

>>> rtl/mfa_ram.sv
module mfa_ram
#(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
)
(
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/mfa_store.sv
`include "motor_feedback_angle_unwrap_speed_filter_defines.svh"

module mfa_store
   import mfa_pkg::*;
#(
   parameter int NUM_MOTORS = NUM_MOTORS_DEF,
   localparam int ADDR_W = (NUM_MOTORS > 1) ? $clog2(NUM_MOTORS) : 1
)
(
   input  logic                      clock,
   input  logic                      reset,
   input  store_ctl_type             ctl,
   input  logic [ADDR_W-1:0]         rd_addr,
   input  logic [ADDR_W-1:0]         wr_addr,
   input  logic [ANGLE_W-1:0]        wr_angle,
   input  logic [TOTAL_W-1:0]        wr_total,
   input  logic signed [SPEED_W-1:0] wr_speed,
   output logic [ANGLE_W-1:0]        rd_angle,
   output logic [TOTAL_W-1:0]        rd_total,
   output logic signed [SPEED_W-1:0] rd_speed
);

   localparam int ANG_MEM_W = ANGLE_W + SPEED_W;

   logic [NUM_MOTORS-1:0] ang_vld_ff, ang_vld_in;
   logic [NUM_MOTORS-1:0] tot_vld_ff, tot_vld_in;
   logic                  ang_hit_ff, ang_hit_in;
   logic                  tot_hit_ff, tot_hit_in;
   logic [ANG_MEM_W-1:0]  ang_rdata;
   logic [TOTAL_W-1:0]    tot_rdata;

   // last angle and filtered speed share one word; totals live apart so clear hits only them
   mfa_ram #(.WIDTH(ANG_MEM_W), .DEPTH(NUM_MOTORS)) u_ang_ram (
      .clock   (clock),
      .wr_en   (ctl.wr_en),
      .wr_addr (wr_addr),
      .wr_data ({wr_angle, wr_speed}),
      .rd_en   (ctl.rd_en),
      .rd_addr (rd_addr),
      .rd_data (ang_rdata)
   );

   mfa_ram #(.WIDTH(TOTAL_W), .DEPTH(NUM_MOTORS)) u_tot_ram (
      .clock   (clock),
      .wr_en   (ctl.wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_total),
      .rd_en   (ctl.rd_en),
      .rd_addr (rd_addr),
      .rd_data (tot_rdata)
   );

   always_comb begin
      ang_vld_in = ang_vld_ff;
      tot_vld_in = tot_vld_ff;
      ang_hit_in = ang_hit_ff;
      tot_hit_in = tot_hit_ff;
      if (ctl.rd_en) begin
         ang_hit_in = ang_vld_ff[rd_addr];
         tot_hit_in = tot_vld_ff[rd_addr];
      end
      if (ctl.wr_en) begin
         ang_vld_in[wr_addr] = 1'b1;
         tot_vld_in[wr_addr] = 1'b1;
      end
      if (ctl.clr_total) begin
         tot_vld_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ang_vld_ff <= '0;
         tot_vld_ff <= '0;
         ang_hit_ff <= 1'b0;
         tot_hit_ff <= 1'b0;
      end else begin
         ang_vld_ff <= ang_vld_in;
         tot_vld_ff <= tot_vld_in;
         ang_hit_ff <= ang_hit_in;
         tot_hit_ff <= tot_hit_in;
      end
   end

   // an entry never written reads as zero
   assign rd_angle = ang_hit_ff ? ang_rdata[ANG_MEM_W-1:SPEED_W] : '0;
   assign rd_speed = ang_hit_ff ? $signed(ang_rdata[SPEED_W-1:0]) : '0;
   assign rd_total = tot_hit_ff ? tot_rdata : '0;

   `MFA_ASSERT_NXT(a_clear_drops_totals, clock, reset, ctl.clr_total, tot_vld_ff == '0, "clear left a total valid")
   `MFA_ASSERT_NXT(a_write_marks_entry, clock, reset, ctl.wr_en, ang_vld_ff[$past(wr_addr)] && tot_vld_ff[$past(wr_addr)], "write did not mark entry valid")
   `MFA_ASSERT_IMP(a_no_rw_overlap, clock, reset, ctl.rd_en, !ctl.wr_en && !ctl.clr_total, "read overlaps write or clear")

endmodule

>>> rtl/mfa_calc.sv
module mfa_calc
   import mfa_pkg::*;
(
   input  logic                       clock,
   input  calc_ctl_type               ctl,
   input  logic [ANGLE_W-1:0]         angle,
   input  logic [ANGLE_W-1:0]         last_angle,
   input  logic [TOTAL_W-1:0]         total,
   input  logic signed [SPEED_W-1:0]  prev_speed,
   input  logic signed [RPM_W-1:0]    rpm,
   input  logic [SCALE_W-1:0]         scale,
   input  logic [WEIGHT_W-1:0]        weight,
   output logic [TOTAL_W-1:0]         total_new,
   output logic signed [SPEED_W-1:0]  speed_new
);

   logic signed [DELTA_W-1:0]  direct, wrapped, abs_direct, abs_wrapped, step;
   logic [WEIGHT_W-1:0]        w_eff;
   logic signed [SPEED_W:0]    diff;

   logic [TOTAL_W-1:0]         total_a_ff, total_a_in;
   logic signed [PROD_W-1:0]   prod_a_ff, prod_a_in;
   logic signed [SPEED_W-1:0]  prev_a_ff, prev_a_in;
   logic signed [SPEED_W-1:0]  samp_b_ff, samp_b_in;
   logic signed [PROD_W-1:0]   acc_c_ff, acc_c_in;

   // shorter of direct and wrapped step; a tie keeps the direct one
   always_comb begin
      direct      = $signed({2'b00, angle}) - $signed({2'b00, last_angle});
      wrapped     = (direct > 0) ? direct - TURN_COUNTS : direct + TURN_COUNTS;
      abs_direct  = (direct < 0) ? -direct : direct;
      abs_wrapped = (wrapped < 0) ? -wrapped : wrapped;
      step        = (abs_wrapped < abs_direct) ? wrapped : direct;
   end

   assign w_eff = (weight > WEIGHT_ONE) ? WEIGHT_ONE : weight;

   always_comb begin
      total_a_in = ctl.ld_read ? total + TOTAL_W'(step) : total_a_ff;
      prod_a_in  = ctl.ld_read ? PROD_W'(rpm) * PROD_W'($signed({1'b0, scale})) : prod_a_ff;
      prev_a_in  = ctl.ld_read ? prev_speed : prev_a_ff;
      samp_b_in  = ctl.ld_samp ? round_q8_sat(prod_a_ff) : samp_b_ff;
      // w*prev + (256-w)*sample folded to sample*256 + w*(prev-sample)
      diff       = (SPEED_W+1)'(prev_a_ff) - (SPEED_W+1)'(samp_b_ff);
      acc_c_in   = ctl.ld_filt
                   ? PROD_W'(diff) * PROD_W'($signed({1'b0, w_eff}))
                     + PROD_W'($signed({samp_b_ff, 8'h00}))
                   : acc_c_ff;
   end

   always_ff @(posedge clock) begin
      total_a_ff <= total_a_in;
      prod_a_ff  <= prod_a_in;
      prev_a_ff  <= prev_a_in;
      samp_b_ff  <= samp_b_in;
      acc_c_ff   <= acc_c_in;
   end

   assign total_new = total_a_ff;
   assign speed_new = round_q8_sat(acc_c_ff);

endmodule

>>> rtl/motor_feedback_angle_unwrap_speed_filter.sv
// Channel  Direction  Beat contents
// req_     in         op, motor_index, angle_raw, speed_rpm, current_raw
// rsp_     out        motor_out, total_angle, smoothed_speed, rpm_out, current_out
// csr_     in         index, wdata (register write, always ready)
//
// A feedback beat runs through accept and memory read, unwrap and rpm multiply,
// sample rounding, filter multiply, and write-back into the rsp register.
// A clear beat or a beat for a motor out of range is taken in idle and gives no rsp.
// Reset clears per-motor valid bits in flip-flops; no memory sweep, ready next cycle.
// A held rsp beat stalls only the write-back cycle of the next report.

`include "motor_feedback_angle_unwrap_speed_filter_defines.svh"

module motor_feedback_angle_unwrap_speed_filter
   import mfa_pkg::*;
#(
   parameter int NUM_MOTORS = NUM_MOTORS_DEF
)
(
   input  logic                        clock,
   input  logic                        reset,

   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic                        req_op,
   input  logic [MOTOR_W-1:0]          req_motor_index,
   input  logic [ANGLE_W-1:0]          req_angle_raw,
   input  logic signed [RPM_W-1:0]     req_speed_rpm,
   input  logic signed [CUR_W-1:0]     req_current_raw,

   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic [MOTOR_W-1:0]          rsp_motor_out,
   output logic signed [TOTAL_W-1:0]   rsp_total_angle,
   output logic signed [SPEED_W-1:0]   rsp_smoothed_speed,
   output logic signed [RPM_W-1:0]     rsp_rpm_out,
   output logic signed [CUR_W-1:0]     rsp_current_out,

   input  logic                        csr_valid,
   output logic                        csr_ready,
   input  logic [CSR_IDX_W-1:0]        csr_index,
   input  logic [CSR_DATA_W-1:0]       csr_wdata
);

   localparam int ADDR_W = (NUM_MOTORS > 1) ? $clog2(NUM_MOTORS) : 1;

   typedef enum logic [2:0] {
      S_IDLE,
      S_READ,
      S_SAMP,
      S_FILT,
      S_DONE
   } state_type;

   state_type                  state_ff, state_in;

   logic [SCALE_W-1:0]         scale_ff, scale_in;
   logic [WEIGHT_W-1:0]        weight_ff, weight_in;

   logic [MOTOR_W-1:0]         motor_ff, motor_in;
   logic [ANGLE_W-1:0]         angle_ff, angle_in;
   logic signed [RPM_W-1:0]    rpm_ff, rpm_in;
   logic signed [CUR_W-1:0]    cur_ff, cur_in;

   logic                       rsp_valid_ff, rsp_valid_in;
   logic [MOTOR_W-1:0]         rsp_motor_ff, rsp_motor_in;
   logic [TOTAL_W-1:0]         rsp_total_ff, rsp_total_in;
   logic signed [SPEED_W-1:0]  rsp_speed_ff, rsp_speed_in;
   logic signed [RPM_W-1:0]    rsp_rpm_ff, rsp_rpm_in;
   logic signed [CUR_W-1:0]    rsp_cur_ff, rsp_cur_in;

   store_ctl_type              st_ctl;
   calc_ctl_type               cc_ctl;
   logic                       req_fire;
   logic                       rsp_load;
   logic                       in_range;

   logic [ANGLE_W-1:0]         st_angle;
   logic [TOTAL_W-1:0]         st_total;
   logic signed [SPEED_W-1:0]  st_speed;
   logic [TOTAL_W-1:0]         total_new;
   logic signed [SPEED_W-1:0]  speed_new;

   assign req_ready = (state_ff == S_IDLE);
   assign req_fire  = req_valid && req_ready;
   assign in_range  = 32'(req_motor_index) < NUM_MOTORS;
   assign csr_ready = 1'b1;

   // Register writes; an index past the map is dropped.
   always_comb begin
      scale_in  = scale_ff;
      weight_in = weight_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_SPEED_SCALE:      scale_in  = csr_wdata[SCALE_W-1:0];
            CSR_SMOOTHING_WEIGHT: weight_in = csr_wdata[WEIGHT_W-1:0];
            default: ;
         endcase
      end
   end

   // Sequencer: read the motor's entry, run the datapath stages, write back and hand off; a clear drops the totals.
   always_comb begin
      state_in = state_ff;
      st_ctl   = '0;
      cc_ctl   = '0;
      rsp_load = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               if (req_op == OP_CLEAR) begin
                  // drop every multi-turn total, no rsp beat
                  st_ctl.clr_total = 1'b1;
               end else if (in_range) begin
                  st_ctl.rd_en = 1'b1;
                  state_in     = S_READ;
               end
            end
         end
         S_READ: begin
            cc_ctl.ld_read = 1'b1;
            state_in       = S_SAMP;
         end
         S_SAMP: begin
            cc_ctl.ld_samp = 1'b1;
            state_in       = S_FILT;
         end
         S_FILT: begin
            cc_ctl.ld_filt = 1'b1;
            state_in       = S_DONE;
         end
         S_DONE: begin
            // hold until the rsp register frees up
            if (!rsp_valid_ff || rsp_ready) begin
               st_ctl.wr_en = 1'b1;
               rsp_load     = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      motor_in = req_fire ? req_motor_index : motor_ff;
      angle_in = req_fire ? req_angle_raw   : angle_ff;
      rpm_in   = req_fire ? req_speed_rpm   : rpm_ff;
      cur_in   = req_fire ? req_current_raw : cur_ff;

      rsp_valid_in = rsp_load ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);
      rsp_motor_in = rsp_load ? motor_ff  : rsp_motor_ff;
      rsp_total_in = rsp_load ? total_new : rsp_total_ff;
      rsp_speed_in = rsp_load ? speed_new : rsp_speed_ff;
      rsp_rpm_in   = rsp_load ? rpm_ff    : rsp_rpm_ff;
      rsp_cur_in   = rsp_load ? cur_ff    : rsp_cur_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         scale_ff     <= SCALE_RESET;
         weight_ff    <= WEIGHT_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         scale_ff     <= scale_in;
         weight_ff    <= weight_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      motor_ff     <= motor_in;
      angle_ff     <= angle_in;
      rpm_ff       <= rpm_in;
      cur_ff       <= cur_in;
      rsp_motor_ff <= rsp_motor_in;
      rsp_total_ff <= rsp_total_in;
      rsp_speed_ff <= rsp_speed_in;
      rsp_rpm_ff   <= rsp_rpm_in;
      rsp_cur_ff   <= rsp_cur_in;
   end

   mfa_store #(.NUM_MOTORS(NUM_MOTORS)) u_store (
      .clock    (clock),
      .reset    (reset),
      .ctl      (st_ctl),
      .rd_addr  (ADDR_W'(req_motor_index)),
      .wr_addr  (ADDR_W'(motor_ff)),
      .wr_angle (angle_ff),
      .wr_total (total_new),
      .wr_speed (speed_new),
      .rd_angle (st_angle),
      .rd_total (st_total),
      .rd_speed (st_speed)
   );

   mfa_calc u_calc (
      .clock      (clock),
      .ctl        (cc_ctl),
      .angle      (angle_ff),
      .last_angle (st_angle),
      .total      (st_total),
      .prev_speed (st_speed),
      .rpm        (rpm_ff),
      .scale      (scale_ff),
      .weight     (weight_ff),
      .total_new  (total_new),
      .speed_new  (speed_new)
   );

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_motor_out      = rsp_motor_ff;
   assign rsp_total_angle    = $signed(rsp_total_ff);
   assign rsp_smoothed_speed = rsp_speed_ff;
   assign rsp_rpm_out        = rsp_rpm_ff;
   assign rsp_current_out    = rsp_cur_ff;

   `MFA_ASSERT_NXT(a_clear_stays_idle, clock, reset, req_fire && req_op == OP_CLEAR, state_ff == S_IDLE, "clear beat started a report")
   `MFA_ASSERT_NXT(a_read_starts, clock, reset, st_ctl.rd_en, state_ff == S_READ && motor_ff == $past(req_motor_index), "report read did not start")
   `MFA_ASSERT_NXT(a_done_loads_rsp, clock, reset, state_ff == S_DONE && (!rsp_valid_ff || rsp_ready), rsp_valid_ff && state_ff == S_IDLE, "write-back did not load rsp")

endmodule

>>> bench/mfa_feedback_checker.sv
`timescale 1ns / 1ps

// Watch all three channels of the angle-unwrap / speed-filter block, keep a
// shadow of its per-motor state, and compare every result beat in order.
module mfa_feedback_checker
   import mfa_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,

   input  logic                      req_valid,
   input  logic                      req_ready,
   input  logic                      req_op,
   input  logic [MOTOR_W-1:0]        req_motor_index,
   input  logic [ANGLE_W-1:0]        req_angle_raw,
   input  logic signed [RPM_W-1:0]   req_speed_rpm,
   input  logic signed [CUR_W-1:0]   req_current_raw,

   input  logic                      rsp_valid,
   input  logic                      rsp_ready,
   input  logic [MOTOR_W-1:0]        rsp_motor_out,
   input  logic signed [TOTAL_W-1:0] rsp_total_angle,
   input  logic signed [SPEED_W-1:0] rsp_smoothed_speed,
   input  logic signed [RPM_W-1:0]   rsp_rpm_out,
   input  logic signed [CUR_W-1:0]   rsp_current_out,

   input  logic                      csr_valid,
   input  logic                      csr_ready,
   input  logic [CSR_IDX_W-1:0]      csr_index,
   input  logic [CSR_DATA_W-1:0]     csr_wdata,

   output int                        fail_count,
   output int                        pending_results,
   output int                        results_checked
);

   typedef struct packed {
      logic [MOTOR_W-1:0]        motor;
      logic signed [TOTAL_W-1:0] total;
      logic signed [SPEED_W-1:0] speed;
      logic signed [RPM_W-1:0]   rpm;
      logic signed [CUR_W-1:0]   cur;
   } wheel_state_type;

   wheel_state_type           wheel_state_q[$];

   logic [SCALE_W-1:0]        scale_cfg;
   logic [WEIGHT_W-1:0]       weight_cfg;
   logic [ANGLE_W-1:0]        angle_last [NUM_MOTORS_DEF];
   logic [TOTAL_W-1:0]        turn_sum   [NUM_MOTORS_DEF];
   logic signed [SPEED_W-1:0] speed_avg  [NUM_MOTORS_DEF];

   // Take the shorter of the direct and the one-turn-wrapped change; a tie keeps direct.
   function automatic int shorter_turn_delta(input logic [ANGLE_W-1:0] prev_angle,
                                             input logic [ANGLE_W-1:0] new_angle);
      int direct;
      int wrapped;
      int dist_direct;
      int dist_wrapped;
      direct       = int'(new_angle) - int'(prev_angle);
      wrapped      = (direct > 0) ? direct - 8192 : direct + 8192;
      dist_direct  = (direct < 0) ? -direct : direct;
      dist_wrapped = (wrapped < 0) ? -wrapped : wrapped;
      return (dist_wrapped < dist_direct) ? wrapped : direct;
   endfunction

   // Divide by 256 rounding half up, clamp to the speed range.
   function automatic logic signed [SPEED_W-1:0] q8_round_clamp(input longint v);
      longint r;
      r = (v + 128) >>> 8;
      if (r > longint'(SPEED_MAX)) begin
         r = longint'(SPEED_MAX);
      end else if (r < longint'(SPEED_MIN)) begin
         r = longint'(SPEED_MIN);
      end
      return SPEED_W'(r);
   endfunction

   task automatic compare_field(input string name, input logic signed [63:0] want,
                                input logic signed [63:0] got);
      if (got !== want) begin
         $error("%s mismatch: expected %0d, got %0d", name, want, got);
         fail_count++;
      end
   endtask

   always @(posedge clock) begin
      wheel_state_type want;
      int              delta;
      longint          speed_sample;
      longint          w;
      if (reset) begin
         scale_cfg  = SCALE_RESET;
         weight_cfg = WEIGHT_RESET;
         foreach (angle_last[i]) begin
            angle_last[i] = '0;
            turn_sum[i]   = '0;
            speed_avg[i]  = '0;
         end
         wheel_state_q.delete();
      end else begin
         // Retire the oldest expectation before anything new is pushed.
         if (rsp_valid && rsp_ready) begin
            if (wheel_state_q.size() == 0) begin
               $error("result beat for motor %0d with no report outstanding", rsp_motor_out);
               fail_count++;
            end else begin
               want = wheel_state_q.pop_front();
               compare_field("motor_out", want.motor, rsp_motor_out);
               compare_field("total_angle", want.total, rsp_total_angle);
               compare_field("smoothed_speed", want.speed, rsp_smoothed_speed);
               compare_field("rpm_out", want.rpm, rsp_rpm_out);
               compare_field("current_out", want.cur, rsp_current_out);
               results_checked++;
            end
         end

         if (csr_valid && csr_ready) begin
            if (csr_index == CSR_SPEED_SCALE) begin
               scale_cfg = csr_wdata[SCALE_W-1:0];
            end else if (csr_index == CSR_SMOOTHING_WEIGHT) begin
               weight_cfg = csr_wdata[WEIGHT_W-1:0];
            end
         end

         if (req_valid && req_ready) begin
            if (req_op == OP_CLEAR) begin
               // Clear touches the totals only.
               foreach (turn_sum[i]) begin
                  turn_sum[i] = '0;
               end
            end else begin
               delta = shorter_turn_delta(angle_last[req_motor_index], req_angle_raw);
               turn_sum[req_motor_index]   = turn_sum[req_motor_index] + TOTAL_W'(delta);
               angle_last[req_motor_index] = req_angle_raw;

               speed_sample = q8_round_clamp(longint'(req_speed_rpm) * longint'(scale_cfg));
               w = (weight_cfg > WEIGHT_ONE) ? longint'(WEIGHT_ONE) : longint'(weight_cfg);
               speed_avg[req_motor_index] = q8_round_clamp(
                  w * longint'(speed_avg[req_motor_index]) +
                  (longint'(WEIGHT_ONE) - w) * speed_sample);

               want.motor = req_motor_index;
               want.total = turn_sum[req_motor_index];
               want.speed = speed_avg[req_motor_index];
               want.rpm   = req_speed_rpm;
               want.cur   = req_current_raw;
               wheel_state_q.push_back(want);
            end
         end
      end
      pending_results = wheel_state_q.size();
   end

endmodule

>>> bench/tb.sv
`timescale 1ns / 1ps

// Bench for the motor feedback angle-unwrap / speed-filter block.
// The top only makes stimulus and gives the verdict; all prediction and
// comparison lives in the checker instance beside the block.
module tb
   import mfa_pkg::*;
();

   // No beat on any channel for this many cycles means the block is hung.
   // The longest quiet stretch of a correct run is the deliberate receiver
   // hold-off of PRESSURE_HOLD, so this leaves ample margin.
   localparam int WATCHDOG_LIMIT  = 2000;
   localparam int NUM_PHASES      = 8;
   localparam int ITEMS_PER_PHASE = 135;
   // Let a feedback beat clear the pipe before touching the registers.
   localparam int SETTLE_CYCLES   = 8;
   localparam int PRESSURE_HOLD   = 200;

   logic                      clock;
   logic                      reset;

   logic                      req_valid;
   logic                      req_ready;
   logic                      req_op;
   logic [MOTOR_W-1:0]        req_motor_index;
   logic [ANGLE_W-1:0]        req_angle_raw;
   logic signed [RPM_W-1:0]   req_speed_rpm;
   logic signed [CUR_W-1:0]   req_current_raw;

   logic                      rsp_valid;
   logic                      rsp_ready;
   logic [MOTOR_W-1:0]        rsp_motor_out;
   logic signed [TOTAL_W-1:0] rsp_total_angle;
   logic signed [SPEED_W-1:0] rsp_smoothed_speed;
   logic signed [RPM_W-1:0]   rsp_rpm_out;
   logic signed [CUR_W-1:0]   rsp_current_out;

   logic                      csr_valid;
   logic                      csr_ready;
   logic [CSR_IDX_W-1:0]      csr_index;
   logic [CSR_DATA_W-1:0]     csr_wdata;

   int fail_count;
   int pending_results;
   int results_checked;

   // Knobs set by the main sequence for the sender and the receiver process.
   int rsp_stall_pct = 25;
   int hold_cycles   = 0;
   bit gaps_on       = 1'b1;

   int idle_cycles    = 0;
   int reports_sent   = 0;
   int clears_sent    = 0;
   int settings_used  = 0;

   // Last angle sent per motor, so random reports can walk smoothly.
   logic [ANGLE_W-1:0] angle_track [NUM_MOTORS_DEF];

   motor_feedback_angle_unwrap_speed_filter u_dut (.*);

   mfa_feedback_checker u_checker (.*);

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // Result side: mostly random ready, now and then a long stall, and on
   // request one long hold-off so the pipe backs up into the request side.
   initial begin
      int n;
      rsp_ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_cycles > 0) begin
            n           = hold_cycles;
            hold_cycles = 0;
            rsp_ready <= 1'b0;
            repeat (n) @(posedge clock);
         end else if (rsp_stall_pct > 0 && $urandom_range(0, 99) < 3) begin
            n = $urandom_range(10, 40);
            rsp_ready <= 1'b0;
            repeat (n) @(posedge clock);
         end else begin
            rsp_ready <= ($urandom_range(0, 99) >= rsp_stall_pct);
         end
      end
   end

   // Count cycles in which no beat moves on any channel.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
          (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("watchdog: no beat moved for %0d cycles", WATCHDOG_LIMIT);
         $display("status: fail");
         $finish;
      end
   end

   // Offer one request beat, hold it until taken, then maybe leave a gap.
   // Valid is only lowered when a gap follows, so back-to-back beats keep
   // valid high without a drop inside the same step.
   task automatic send_beat(input logic op, input logic [MOTOR_W-1:0] m,
                            input logic [ANGLE_W-1:0] ang,
                            input logic signed [RPM_W-1:0] rpm,
                            input logic signed [CUR_W-1:0] cur);
      int pick;
      int gap;
      req_valid       <= 1'b1;
      req_op          <= op;
      req_motor_index <= m;
      req_angle_raw   <= ang;
      req_speed_rpm   <= rpm;
      req_current_raw <= cur;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      if (op == OP_FEEDBACK) begin
         angle_track[m] = ang;
         reports_sent++;
      end else begin
         clears_sent++;
      end

      // Mostly short gaps, a few long ones.
      gap = 0;
      if (gaps_on) begin
         pick = $urandom_range(0, 99);
         if (pick < 50) begin
            gap = 0;
         end else if (pick < 88) begin
            gap = $urandom_range(1, 3);
         end else if (pick < 98) begin
            gap = $urandom_range(4, 12);
         end else begin
            gap = $urandom_range(20, 60);
         end
      end
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Drain every outstanding result, let the pipe empty, then write both
   // registers back to back with valid held high between the two beats.
   // Wait for a clock edge first so the checker has counted the last request beat.
   task automatic configure(input logic [CSR_DATA_W-1:0] scale,
                            input logic [CSR_DATA_W-1:0] weight);
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_results != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= CSR_SPEED_SCALE;
      csr_wdata <= scale;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_index <= CSR_SMOOTHING_WEIGHT;
      csr_wdata <= weight;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      settings_used++;
   endtask

   // Random traffic: mostly smooth per-motor angle walks with random speed,
   // some exact half-turn steps, some standstill, some wild jumps, and an
   // occasional clear beat.
   task automatic random_phase(input int count);
      int                      r;
      logic [MOTOR_W-1:0]      m;
      logic [ANGLE_W-1:0]      ang;
      logic signed [RPM_W-1:0] rpm;
      for (int k = 0; k < count; k++) begin
         r = $urandom_range(0, 99);
         m = MOTOR_W'($urandom_range(0, NUM_MOTORS_DEF - 1));
         if (r < 3) begin
            send_beat(OP_CLEAR, m, ANGLE_W'($urandom), RPM_W'($urandom), CUR_W'($urandom));
         end else begin
            r = $urandom_range(0, 99);
            if (r < 65) begin
               ang = angle_track[m] + ANGLE_W'($urandom_range(0, 600)) - ANGLE_W'(300);
            end else if (r < 75) begin
               ang = angle_track[m] + ANGLE_W'(4096);
            end else if (r < 80) begin
               ang = angle_track[m];
            end else begin
               ang = ANGLE_W'($urandom);
            end
            if ($urandom_range(0, 1) == 1) begin
               rpm = RPM_W'($urandom);
            end else begin
               rpm = RPM_W'($urandom_range(0, 1000)) - RPM_W'(500);
            end
            send_beat(OP_FEEDBACK, m, ang, rpm, CUR_W'($urandom));
         end
      end
   endtask

   initial begin
      logic [CSR_DATA_W-1:0] phase_scale  [NUM_PHASES];
      logic [CSR_DATA_W-1:0] phase_weight [NUM_PHASES];

      reset           <= 1'b1;
      req_valid       <= 1'b0;
      req_op          <= OP_FEEDBACK;
      req_motor_index <= '0;
      req_angle_raw   <= '0;
      req_speed_rpm   <= '0;
      req_current_raw <= '0;
      csr_valid       <= 1'b0;
      csr_index       <= CSR_SPEED_SCALE;
      csr_wdata       <= '0;
      foreach (angle_track[i]) begin
         angle_track[i] = '0;
      end

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // Directed part, reset register values first.
      send_beat(OP_FEEDBACK, 0, 0, 0, 0);                // first report, no motion
      send_beat(OP_FEEDBACK, 0, 4096, 100, 5);           // half turn forward: tie, keep direct
      send_beat(OP_FEEDBACK, 0, 0, -100, -5);            // half turn back: tie, keep direct
      send_beat(OP_FEEDBACK, 0, 8191, 3000, 0);          // one count back across zero
      send_beat(OP_FEEDBACK, 0, 0, 3000, 0);             // one count forward across zero
      send_beat(OP_FEEDBACK, 1, 8191, 32767, 32767);     // first report for motor 1
      send_beat(OP_FEEDBACK, 2, 1, -32768, -32768);
      send_beat(OP_FEEDBACK, 3, 5000, -1, -1);           // first report, wrapped is shorter
      send_beat(OP_FEEDBACK, 3, 904, 0, 16'h5555);       // tie in the negative direction
      send_beat(OP_CLEAR, 3, 8191, -1, -1);              // clear with all payload bits set
      send_beat(OP_FEEDBACK, 0, 10, 12345, -2);
      send_beat(OP_FEEDBACK, 3, 904, 7, 0);              // last angle survives the clear

      // Largest scale, no smoothing: drive the sample into both clamps.
      configure(CSR_DATA_W'(16'hFFFF), CSR_DATA_W'(0));
      send_beat(OP_FEEDBACK, 1, 8191, 32767, 1);
      send_beat(OP_FEEDBACK, 2, 1, -32768, 2);
      send_beat(OP_FEEDBACK, 3, 100, 1, 3);
      send_beat(OP_FEEDBACK, 0, 10, -1, 4);

      // Weight of exactly one: filtered speed must hold.
      configure(CSR_DATA_W'(16'hFFFF), CSR_DATA_W'(256));
      send_beat(OP_FEEDBACK, 1, 0, -32768, 0);
      send_beat(OP_FEEDBACK, 2, 4097, 32767, 0);

      // Weight field all ones, above one: acts as a hold as well.
      configure(CSR_DATA_W'(3000), CSR_DATA_W'(16'hFFFF));
      send_beat(OP_FEEDBACK, 3, 6000, 20000, 0);

      // Zero scale: the filter only decays toward zero.
      configure(CSR_DATA_W'(0), CSR_DATA_W'(128));
      send_beat(OP_FEEDBACK, 1, 100, 32767, 0);
      send_beat(OP_FEEDBACK, 2, 4097, -32768, 0);
      send_beat(OP_CLEAR, 0, 0, 0, 0);

      // Random phases, each under its own register setting.
      phase_scale  = '{CSR_DATA_W'(SCALE_RESET), CSR_DATA_W'(16'hFFFF), CSR_DATA_W'($urandom),
                       CSR_DATA_W'(0), CSR_DATA_W'($urandom), CSR_DATA_W'(1),
                       CSR_DATA_W'($urandom), CSR_DATA_W'(16'hFFFF)};
      phase_weight = '{CSR_DATA_W'(WEIGHT_RESET), CSR_DATA_W'(0),
                       CSR_DATA_W'($urandom_range(0, 256)), CSR_DATA_W'(256),
                       CSR_DATA_W'($urandom), CSR_DATA_W'(1),
                       CSR_DATA_W'($urandom_range(0, 256)), CSR_DATA_W'(255)};

      for (int p = 0; p < NUM_PHASES; p++) begin
         configure(phase_scale[p], phase_weight[p]);
         // Phase 1 runs flat out on both sides; phase 2 holds the result
         // side off while the sender keeps pushing, so the block fills up
         // and has to stall its request side; phase 6 stalls hard.
         gaps_on       = !(p == 1 || p == 2);
         rsp_stall_pct = (p == 1) ? 0 : (p == 6) ? 60 : 25;
         if (p == 2) begin
            hold_cycles = PRESSURE_HOLD;
         end
         random_phase(ITEMS_PER_PHASE);
      end

      // Drain, then give the block a few more cycles to show any stray beat.
      rsp_stall_pct = 0;
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_results != 0) @(posedge clock);
      repeat (SETTLE_CYCLES + 12) @(posedge clock);

      $display("run covered %0d feedback reports and %0d clear beats over %0d register settings",
               reports_sent, clears_sent, settings_used);
      $display("%0d result beats compared, %0d mismatches", results_checked, fail_count);
      if (fail_count == 0 && pending_results == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule

>>> sim.f
+incdir+rtl
rtl/mfa_pkg.sv
rtl/mfa_ram.sv
rtl/mfa_store.sv
rtl/mfa_calc.sv
rtl/motor_feedback_angle_unwrap_speed_filter.sv
bench/mfa_feedback_checker.sv
bench/tb.sv
